>>> hdl/mdpa_pkg.sv
// Package for the modular dot-product accumulator: sizes, reset values and sequencer states.
`default_nettype none

package mdpa_pkg;

    // Terms summed before the block sum is folded into the running residue.
    localparam int BLOCK_TERMS = 4096;

    localparam int VAL_W   = 8;
    localparam int MOD_W   = 9;
    localparam int COUNT_W = (BLOCK_TERMS > 1) ? $clog2(BLOCK_TERMS) : 1;
    // Wide enough for BLOCK_TERMS products of (-128) * (-128).
    localparam int SUM_W   = 16 + $clog2(BLOCK_TERMS);
    localparam int FOLD_W  = SUM_W + 1;
    localparam int ITER_W  = $clog2(FOLD_W + 1);

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(251);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } mdpa_state_t;

endpackage

`default_nettype wire

>>> hdl/modular_dot_product_accumulator.sv
// Top level of the modular dot-product accumulator.
`default_nettype none

// Each transfer brings one pair of signed 8-bit residues; their product is
// added to a wide block sum in the cycle the transfer is taken, and a term
// that does not end a block leaves the input ready for the next term. A term
// that closes a block of BLOCK_TERMS terms, or carries last, starts a fold:
// the load state forms the signed sum of block sum and running residue, the
// divide state makes one bit-serial compare-and-subtract step per bit of that
// sum (FOLD_W bits, 29 at the default block size) and the done state centres
// the remainder. in_stall stays high from the load state until the fold ends.
// The fold of a last term also waits until the output register is free. The
// modulus is taken from modulus_wr_data whenever modulus_wr_en is high and
// should only change while the block is idle. Reset needs no clearing pass.
module modular_dot_product_accumulator (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  modulus_wr_en,
    input  wire        [mdpa_pkg::MOD_W-1:0]     modulus_wr_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire signed [mdpa_pkg::VAL_W-1:0]     a_value,
    input  wire signed [mdpa_pkg::VAL_W-1:0]     b_value,
    input  wire                                  last,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [mdpa_pkg::VAL_W-1:0]    result_value
);
    import mdpa_pkg::*;

    mdpa_state_t                state_reg, state_next;
    logic        [MOD_W-1:0]    modulus_reg, modulus_next;
    logic signed [SUM_W-1:0]    block_sum_reg, block_sum_next;
    logic        [COUNT_W-1:0]  count_reg, count_next;
    logic signed [VAL_W-1:0]    running_reg, running_next;
    logic                       last_reg, last_next;
    logic        [FOLD_W-1:0]   mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic        [MOD_W-1:0]    rem_reg, rem_next;
    logic        [ITER_W-1:0]   iter_reg, iter_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0]    result_reg, result_next;

    logic                       accept;
    logic                       block_end;
    logic                       out_free;
    logic signed [2*VAL_W-1:0]  product;
    logic signed [FOLD_W-1:0]   fold_value;
    logic        [MOD_W:0]      shifted;
    logic        [MOD_W:0]      mod_ext;
    logic        [MOD_W-1:0]    pos_rem;
    logic        [MOD_W:0]      half;
    logic signed [MOD_W:0]      centred;
    logic signed [VAL_W-1:0]    fold_result;

    assign accept    = in_valid && !in_stall;
    assign block_end = last || (count_reg == COUNT_W'(BLOCK_TERMS - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign product   = a_value * b_value;
    assign mod_ext   = {1'b0, modulus_reg};

    // Signed total to be reduced; its magnitude is divided bit by bit.
    assign fold_value = FOLD_W'(running_reg) + FOLD_W'(block_sum_reg);
    assign shifted    = {rem_reg, mag_reg[FOLD_W-1]};

    // A nonzero remainder of a negative total is turned into m - r, then the
    // upper half of the range is moved down by m.
    assign pos_rem     = (neg_reg && (rem_reg != '0)) ? (modulus_reg - rem_reg) : rem_reg;
    assign half        = (mod_ext + (MOD_W+1)'(1)) >> 1;
    assign centred     = ({1'b0, pos_rem} >= half) ? signed'({1'b0, pos_rem} - mod_ext)
                                                   : signed'({1'b0, pos_rem});
    assign fold_result = (modulus_reg < MOD_W'(2)) ? '0 : centred[VAL_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && block_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        out_valid    = out_valid_reg;
        result_value = result_reg;
    end

    always_comb
    begin
        modulus_next   = modulus_wr_en ? modulus_wr_data : modulus_reg;
        block_sum_next = block_sum_reg;
        count_next     = count_reg;
        running_next   = running_reg;
        last_next      = last_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    block_sum_next = block_sum_reg + SUM_W'(product);
                    count_next     = block_end ? '0 : count_reg + COUNT_W'(1);
                    last_next      = last;
                end
            end
            ST_LOAD:
            begin
                neg_next       = fold_value[FOLD_W-1];
                mag_next       = fold_value[FOLD_W-1] ? unsigned'(-fold_value)
                                                      : unsigned'(fold_value);
                block_sum_next = '0;
                rem_next       = '0;
                iter_next      = ITER_W'(FOLD_W);
            end
            ST_DIV:
            begin
                if (shifted >= mod_ext)
                begin
                    rem_next = MOD_W'(shifted - mod_ext);
                end
                else
                begin
                    rem_next = MOD_W'(shifted);
                end
                mag_next  = mag_reg << 1;
                iter_next = iter_reg - ITER_W'(1);
            end
            ST_DONE:
            begin
                if (!last_reg)
                begin
                    running_next = fold_result;
                end
                else if (out_free)
                begin
                    result_next    = fold_result;
                    out_valid_next = 1'b1;
                    running_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MODULUS_RESET;
            block_sum_reg <= '0;
            count_reg     <= '0;
            running_reg   <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            block_sum_reg <= block_sum_next;
            count_reg     <= count_next;
            running_reg   <= running_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        iter_reg   <= iter_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

>>> hdl/mdpa_checker.sv
// Port-level checks for the modular dot-product accumulator, bound to the top level.
`default_nettype none

module mdpa_checker (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    input  wire                                  in_stall,
    input  wire                                  last,
    input  wire                                  out_valid,
    input  wire                                  out_stall,
    input  wire signed [mdpa_pkg::VAL_W-1:0]     result_value
);

    // A result that is held back must stay put until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled result changed or was dropped");

    // The final term always starts a fold, during which in_stall is held high.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall ##1 in_stall)
    else $error("no fold after the final term");

    // A result only appears at the end of a fold.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a fold");

endmodule

bind modular_dot_product_accumulator mdpa_checker u_mdpa_checker (.*);

`default_nettype wire

>>> sim/modular_dot_product_accumulator_tb.sv
// Self-checking testbench for the modular dot-product accumulator.
`timescale 1ns / 100ps

module modular_dot_product_accumulator_tb;

    import mdpa_pkg::*;

    // One fold spans the load state, one step per bit of the sum and the centring state.
    localparam int FOLD_CYCLES    = FOLD_W + 2;
    localparam int SETTLE_CYCLES  = 2 * FOLD_CYCLES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_TERMS   = 1950;

    logic                    clk;
    logic                    rst_n;
    logic                    modulus_wr_en;
    logic [MOD_W-1:0]        modulus_wr_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic                    last;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [VAL_W-1:0] result_value;

    // Predicted state of the accumulator.
    logic [MOD_W-1:0]        cur_modulus;
    logic signed [VAL_W-1:0] dot_residue;
    longint                  block_total;
    int                      block_terms;

    logic signed [VAL_W-1:0] expected_residues[$];
    logic signed [VAL_W-1:0] wanted_residue;

    int terms_sent;
    int dot_products;
    int results_checked;
    int failures;
    int modulus_settings;
    int burst_left;
    int idle_cycles;
    int stall_mode;
    int stall_left;
    int stall_phase;

    modular_dot_product_accumulator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .a_value         (a_value),
        .b_value         (b_value),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_value    (result_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [VAL_W-1:0] centred_fold(input longint total);
        longint m;
        longint r;
        m = longint'(cur_modulus);
        if (m < 2)
            return '0;
        r = total % m;
        if (r < 0)
            r += m;
        if (r >= (m + 1) / 2)
            r -= m;
        // Moduli above 256 leave a residue that only keeps its low eight bits.
        return r[VAL_W-1:0];
    endfunction

    task automatic accumulate_term(input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b,
                                   input logic lst);
        block_total += longint'(a) * longint'(b);
        block_terms++;
        if (block_terms >= BLOCK_TERMS || lst)
        begin
            dot_residue = centred_fold(longint'(dot_residue) + block_total);
            block_total = 0;
            block_terms = 0;
        end
        if (lst)
        begin
            expected_residues.push_back(dot_residue);
            dot_residue = '0;
            dot_products++;
        end
    endtask

    // Drives one term and returns once its transfer has been taken.
    task automatic send_term(input logic signed [VAL_W-1:0] a,
                             input logic signed [VAL_W-1:0] b,
                             input logic lst);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid = 1'b1;
        a_value  = a;
        b_value  = b;
        last     = lst;
        do
            @(posedge clk);
        while (in_stall);
        accumulate_term(a, b, lst);
        terms_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        release_input();
        while (expected_residues.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_modulus(input int value);
        wait_drained();
        // A fold at a block end gives no result, so let any such fold finish.
        repeat (SETTLE_CYCLES) @(negedge clk);
        modulus_wr_en   = 1'b1;
        modulus_wr_data = MOD_W'(value);
        @(negedge clk);
        modulus_wr_en   = 1'b0;
        cur_modulus     = MOD_W'(value);
        modulus_settings++;
    endtask

    function automatic logic signed [VAL_W-1:0] random_residue();
        case ($urandom_range(0, 5))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return VAL_W'($urandom_range(0, 6) - 3);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic int random_modulus();
        int corner_moduli[6] = '{0, 1, 2, 256, 257, 511};
        case ($urandom_range(0, 9))
            0: return corner_moduli[$urandom_range(0, 5)];
            1: return $urandom_range(257, 511);
            default: return $urandom_range(2, 256);
        endcase
    endfunction

    task automatic send_dot_product(input int len);
        for (int i = 1; i <= len; i++)
            send_term(random_residue(), random_residue(), i == len);
    endtask

    task automatic test_default_modulus();
        send_term(8'sd127, 8'sd127, 1'b1);
        send_term(-8'sd128, -8'sd128, 1'b1);
        send_term(-8'sd128, 8'sd127, 1'b0);
        send_term(8'sd0, 8'sd0, 1'b1);
    endtask

    task automatic test_modulus_extremes();
        int moduli[7] = '{2, 256, 0, 1, 257, 511, 3};
        foreach (moduli[i])
        begin
            set_modulus(moduli[i]);
            send_term(8'sd127, -8'sd128, 1'b0);
            send_term(-8'sd128, -8'sd128, 1'b1);
            send_term(8'sd127, 8'sd127, 1'b1);
        end
    endtask

    task automatic test_random_dot_products();
        int start_terms;
        int products_left;
        int len;
        start_terms   = terms_sent;
        products_left = 0;
        while (terms_sent - start_terms < RANDOM_TERMS)
        begin
            if (products_left == 0)
            begin
                set_modulus(random_modulus());
                products_left = $urandom_range(3, 20);
            end
            case ($urandom_range(0, 19))
                0: len = $urandom_range(41, 200);
                1, 2, 3, 4, 5: len = $urandom_range(9, 40);
                default: len = $urandom_range(1, 8);
            endcase
            send_dot_product(len);
            products_left--;
            if ($urandom_range(0, 30) == 0)
                wait_drained();
        end
    endtask

    // Receiver stall pattern in one of four randomly chosen modes.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = $urandom_range(0, 1);
            2: out_stall = (stall_phase % 7) < 3;
            default: out_stall = ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_residues.size() == 0)
            begin
                $error("result_value: no result expected, actual %0d", result_value);
                failures++;
            end
            else
            begin
                wanted_residue = expected_residues.pop_front();
                results_checked++;
                if (result_value !== wanted_residue)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           wanted_residue, result_value);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("modular_dot_product_accumulator_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n           = 1'b0;
        modulus_wr_en   = 1'b0;
        modulus_wr_data = '0;
        in_valid        = 1'b0;
        a_value         = '0;
        b_value         = '0;
        last            = 1'b0;
        out_stall       = 1'b0;
        stall_mode      = 0;
        stall_left      = 0;
        stall_phase     = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        cur_modulus     = MODULUS_RESET;
        dot_residue     = '0;
        block_total     = 0;
        block_terms     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_modulus();
        test_modulus_extremes();
        test_random_dot_products();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d terms in %0d dot products under %0d modulus settings,",
                 terms_sent, dot_products, modulus_settings);
        $display("with bursty input and stalled output; %0d results checked, %0d failures.",
                 results_checked, failures);
        if (failures == 0 && expected_residues.size() == 0)
            $display("modular_dot_product_accumulator_tb OK");
        else
            $display("modular_dot_product_accumulator_tb NOT OK");
        $finish;
    end

endmodule
